// ===== sv/score_mean_median_mode_top_defines.svh =====
// Assertion macros used by the block's top module.
`ifndef SCORE_MEAN_MEDIAN_MODE_TOP_DEFINES_SVH
`define SCORE_MEAN_MEDIAN_MODE_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SMM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/smm_pkg.sv =====
package smm_pkg;

  // Sizes of the histogram and the set.
  localparam int VALUE_BINS = 128;
  localparam int BIN_W      = 7;
  localparam int SWP_W      = BIN_W + 1;
  localparam int MAX_ITEMS  = 1024;
  localparam int CNT_W      = 11;
  localparam int SUM_W      = 17;

  // Result field widths.
  localparam int FRAC_W = 8;
  localparam int AVG_W  = 15;
  localparam int MED_W  = 8;
  localparam int WORD_W = 64;
  localparam int MODE_W = 2 * WORD_W;

  // Mean divider: one quotient bit per step over the whole scaled sum.
  localparam int DIV_W  = SUM_W + FRAC_W;
  localparam int STEP_W = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_MARK,
    ST_OUT0,
    ST_OUT1
  } smm_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // request accepted: read its bin, count it
    logic update;     // write back the incremented bin
    logic scan_init;  // clear walk results and start the divider
    logic sweep_clr;  // restart the bin sweep
    logic sweep_en;   // advance the bin sweep
    logic pass;       // 0: rank and maximum walk, 1: mode marking
    logic word;       // which half of the mode bitmap is shown
    logic clear;      // empty the store for the next set
  } smm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;
    logic div_done;
  } smm_sts_t;

endpackage

// ===== sv/smm_ram.sv =====
module smm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/smm_div.sv =====
module smm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [smm_pkg::DIV_W-1:0] dividend_i,
  input  logic [smm_pkg::CNT_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [smm_pkg::AVG_W-1:0] quot_o
);

  import smm_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W:0]    rem_sh;
  logic              fits;

  // Restoring division: the dividend shifts out at the top while quotient
  // bits shift in at the bottom of the same register.
  always_comb begin
    rem_sh = {rem_q, dq_q[DIV_W-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    step_d = step_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      dvs_d = divisor_i;
      rem_d = '0;
      if (divisor_i == '0) begin
        // An empty set has a mean of zero.
        dq_d   = '0;
        step_d = '0;
      end else begin
        dq_d   = dividend_i;
        step_d = STEP_W'(DIV_W);
      end
    end else if (step_q != '0) begin
      rem_d  = fits ? CNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CNT_W-1:0];
      dq_d   = {dq_q[DIV_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign done_o = step_q == '0;
  assign quot_o = dq_q[AVG_W-1:0];

endmodule

// ===== sv/smm_dp.sv =====
module smm_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smm_pkg::smm_cmd_t          cmd_i,
  output smm_pkg::smm_sts_t          sts_o,
  input  logic [smm_pkg::BIN_W-1:0]  score_i,
  output logic [smm_pkg::AVG_W-1:0]  average_q8_o,
  output logic [smm_pkg::MED_W-1:0]  median_x2_o,
  output logic [smm_pkg::CNT_W-1:0]  max_count_o,
  output logic [smm_pkg::CNT_W-1:0]  item_count_o,
  output logic [smm_pkg::WORD_W-1:0] mode_bits_o,
  output logic                       overflow_o
);

  import smm_pkg::*;

  // Set totals.
  logic [CNT_W-1:0]      cnt_q;
  logic [SUM_W-1:0]      sum_q;
  logic                  drop_q;
  logic [VALUE_BINS-1:0] vld_q;

  // Bin update of the request in flight.
  logic [BIN_W-1:0] sc_q;
  logic             ok_q;
  logic             room;

  // Bin sweep and its read pipeline.
  logic [SWP_W-1:0] sweep_q;
  logic             pv_q;
  logic [BIN_W-1:0] pbin_q;
  logic             vbit_q;
  logic             issue;

  // Walk results.
  logic [CNT_W-1:0]  seen_q;
  logic [CNT_W-1:0]  max_q;
  logic              flo_q, fhi_q;
  logic [BIN_W-1:0]  lo_q, hi_q;
  logic [MODE_W-1:0] mode_q;
  logic [CNT_W-1:0]  seen_n, rlo, rhi, hv;

  // Histogram memory signals.
  logic             ram_we, ram_re;
  logic [BIN_W-1:0] ram_raddr;
  logic [CNT_W-1:0] ram_wdata, ram_rdata;
  logic             div_done;

  assign room      = cnt_q < CNT_W'(MAX_ITEMS);
  assign issue     = sweep_q != SWP_W'(VALUE_BINS);
  assign hv        = vbit_q ? ram_rdata : '0;
  assign seen_n    = seen_q + hv;
  assign rlo       = (cnt_q - CNT_W'(1)) >> 1;
  assign rhi       = cnt_q >> 1;
  assign ram_we    = cmd_i.update && ok_q;
  assign ram_wdata = hv + CNT_W'(1);
  assign ram_re    = cmd_i.load || (cmd_i.sweep_en && issue);
  assign ram_raddr = cmd_i.load ? score_i : sweep_q[BIN_W-1:0];

  smm_ram #(
    .WIDTH(CNT_W),
    .DEPTH(VALUE_BINS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sc_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  smm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.scan_init),
    .dividend_i ({sum_q, {FRAC_W{1'b0}}}),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (average_q8_o)
  );

  // Totals and bin valid bits; a bin that is not valid reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      drop_q <= 1'b0;
      vld_q  <= '0;
    end else if (cmd_i.clear) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      drop_q <= 1'b0;
      vld_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        if (room) begin
          cnt_q <= cnt_q + CNT_W'(1);
          sum_q <= sum_q + SUM_W'(score_i);
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (ram_we) begin
        vld_q[sc_q] <= 1'b1;
      end
    end
  end

  // Sweep control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      pv_q    <= 1'b0;
    end else if (cmd_i.sweep_clr) begin
      sweep_q <= '0;
      pv_q    <= 1'b0;
    end else if (cmd_i.sweep_en) begin
      pv_q <= issue;
      if (issue) begin
        sweep_q <= sweep_q + SWP_W'(1);
      end
    end
  end

  // Read side registers: the bin and its valid bit travel with the read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sc_q   <= score_i;
      ok_q   <= room;
      vbit_q <= vld_q[score_i];
    end else if (cmd_i.sweep_en && issue) begin
      pbin_q <= sweep_q[BIN_W-1:0];
      vbit_q <= vld_q[sweep_q[BIN_W-1:0]];
    end
  end

  // Walk: ranks of the two middle values and the highest count on the first
  // pass, every bin at that count on the second.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      seen_q <= '0;
      max_q  <= '0;
      flo_q  <= 1'b0;
      fhi_q  <= 1'b0;
      lo_q   <= '0;
      hi_q   <= '0;
      mode_q <= '0;
    end else if (cmd_i.sweep_en && pv_q) begin
      if (!cmd_i.pass) begin
        seen_q <= seen_n;
        if (hv > max_q) begin
          max_q <= hv;
        end
        if (!flo_q && (seen_n > rlo)) begin
          flo_q <= 1'b1;
          lo_q  <= pbin_q;
        end
        if (!fhi_q && (seen_n > rhi)) begin
          fhi_q <= 1'b1;
          hi_q  <= pbin_q;
        end
      end else if ((cnt_q != '0) && (hv == max_q)) begin
        mode_q[pbin_q] <= 1'b1;
      end
    end
  end

  assign sts_o.sweep_done = !issue && !pv_q;
  assign sts_o.div_done   = div_done;

  assign median_x2_o  = {1'b0, lo_q} + {1'b0, hi_q};
  assign max_count_o  = max_q;
  assign item_count_o = cnt_q;
  assign mode_bits_o  = cmd_i.word ? mode_q[MODE_W-1:WORD_W] : mode_q[WORD_W-1:0];
  assign overflow_o   = drop_q;

endmodule

// ===== sv/smm_ctrl.sv =====
module smm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              last_item_i,
  output logic              busy,
  output logic              result_valid_o,
  output smm_pkg::smm_cmd_t cmd_o,
  input  smm_pkg::smm_sts_t sts_i
);

  import smm_pkg::*;

  smm_state_e state_q, state_d;
  logic       last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The mark of the accepted request decides whether a report follows.
  always_ff @(posedge clk_i) begin
    if (cmd_o.load) begin
      last_q <= last_item_i;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    busy           = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
        if (start) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (last_q) begin
          cmd_o.scan_init = 1'b1;
          cmd_o.sweep_clr = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.sweep_en = 1'b1;
        if (sts_i.sweep_done) begin
          cmd_o.sweep_clr = 1'b1;
          state_d         = ST_MARK;
        end
      end
      ST_MARK: begin
        cmd_o.sweep_en = 1'b1;
        cmd_o.pass     = 1'b1;
        if (sts_i.sweep_done && sts_i.div_done) begin
          state_d = ST_OUT0;
        end
      end
      ST_OUT0: begin
        result_valid_o = 1'b1;
        state_d        = ST_OUT1;
      end
      ST_OUT1: begin
        result_valid_o = 1'b1;
        cmd_o.word     = 1'b1;
        cmd_o.clear    = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/score_mean_median_mode_top.sv =====
// Busy is high in the cycle after each accepted request.
// A request marked last starts the report: its two results follow two bin sweeps
// through the single-port histogram read; busy stays high until after them.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset empties the histogram at once through per-bin valid bits.
`include "score_mean_median_mode_top_defines.svh"

module score_mean_median_mode_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [smm_pkg::BIN_W-1:0]  score_i,
  input  logic                       last_item_i,
  output logic                       result_valid_o,
  output logic [smm_pkg::AVG_W-1:0]  average_q8_o,
  output logic [smm_pkg::MED_W-1:0]  median_x2_o,
  output logic [smm_pkg::CNT_W-1:0]  max_count_o,
  output logic [smm_pkg::CNT_W-1:0]  item_count_o,
  output logic [smm_pkg::WORD_W-1:0] mode_bits_o,
  output logic                       word_index_o,
  output logic                       overflow_o,
  output logic                       last_result_o
);

  import smm_pkg::*;

  smm_cmd_t cmd;
  smm_sts_t sts;

  smm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .last_item_i    (last_item_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  smm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .score_i      (score_i),
    .average_q8_o (average_q8_o),
    .median_x2_o  (median_x2_o),
    .max_count_o  (max_count_o),
    .item_count_o (item_count_o),
    .mode_bits_o  (mode_bits_o),
    .overflow_o   (overflow_o)
  );

  // Word number and final flag are one signal: low on the first result, high on the second.
  assign word_index_o  = cmd.word;
  assign last_result_o = cmd.word;

  // An accepted request always occupies the following cycle.
  `SMM_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept not followed by busy")
  // The lower mode word is always followed by the upper one.
  `SMM_ASSERT_NEXT(a_word_pair, clk_i, rst_ni, result_valid_o && !word_index_o, result_valid_o && word_index_o, "second result missing")
  // A report holds exactly two results.
  `SMM_ASSERT_NEXT(a_two_only, clk_i, rst_ni, result_valid_o && word_index_o, !result_valid_o, "extra result after report")
  // No request is taken while results are shown.
  `SMM_ASSERT_IMPLY(a_out_busy, clk_i, rst_ni, result_valid_o, busy, "result while idle")

endmodule
